// ----- sv/hfa_pkg.sv -----
// Shared constants, codes and types of the hole-fit allocator.
`timescale 1ns / 1ps

package hfa_pkg;

    // Table geometry
    localparam int MAX_HOLES  = 32;
    localparam int ADDR_BITS  = 20;
    localparam int SIZE_W     = ADDR_BITS + 1;
    localparam int IDX_W      = $clog2(MAX_HOLES);
    localparam int CNT_W      = $clog2(MAX_HOLES + 1);
    localparam int SUM_W      = SIZE_W + IDX_W;
    localparam int ENTRY_W    = 1 + SIZE_W + ADDR_BITS;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int FIT_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SIZE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE = 1'd1;

    // Register reset values
    localparam logic [FIT_W-1:0]  FIT_MODE_RESET    = 2'd0;
    localparam logic [SIZE_W-1:0] MEMORY_SIZE_RESET = SIZE_W'(4096);

    // Fit policies (code 3 behaves as first fit)
    localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

    // Operations
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] STS_COMPACT   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_OP_DONE   = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [SIZE_W-1:0]    request_size;
        logic [ADDR_BITS-1:0] entry_base;
        logic [SIZE_W-1:0]    entry_size;
        logic                 entry_free;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_BITS-1:0] granted_base;
        logic [CNT_W-1:0]     hole_count;
    } out_item_t;

    typedef struct packed {
        logic                 free;
        logic [SIZE_W-1:0]    size;
        logic [ADDR_BITS-1:0] base;
    } hole_entry_t;

    // Controller -> datapath
    typedef struct packed {
        logic take_item;
        logic scan;
        logic decide;
        logic shift;
        logic wr_used;
        logic wr_rem;
        logic table_op;
        logic load_out;
    } hfa_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] new_func;
        logic              scan_done;
        logic              found;
        logic              full;
        logic              shift_last;
    } hfa_sts_t;

endpackage

// ----- sv/hfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/hfa_datapath.sv -----
// Datapath of the hole-fit allocator: hole table, scan, shift and result registers.
`timescale 1ns / 1ps

module hfa_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  hfa_pkg::in_item_t                in_data,
    input  hfa_pkg::hfa_cmd_t                cmd,
    output hfa_pkg::hfa_sts_t                sts,
    output hfa_pkg::out_item_t               out_data
);

    // Configuration
    logic [hfa_pkg::FIT_W-1:0]     fit_mode_reg, fit_mode_next;
    logic [hfa_pkg::SIZE_W-1:0]    memory_size_reg, memory_size_next;

    // Control state
    logic [hfa_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [hfa_pkg::CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                          eval_vld_reg, eval_vld_next;
    logic                          found_reg, found_next;
    logic                          pend_reg, pend_next;

    // Payload
    hfa_pkg::in_item_t             item_reg, item_next;
    logic [hfa_pkg::IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic [hfa_pkg::IDX_W-1:0]     pick_idx_reg, pick_idx_next;
    logic [hfa_pkg::ADDR_BITS-1:0] pick_base_reg, pick_base_next;
    logic [hfa_pkg::SIZE_W-1:0]    pick_size_reg, pick_size_next;
    logic [hfa_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [hfa_pkg::IDX_W-1:0]     ptr_reg, ptr_next;
    logic [hfa_pkg::IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [hfa_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [hfa_pkg::ADDR_BITS-1:0] res_base_reg, res_base_next;
    hfa_pkg::out_item_t            out_data_reg, out_data_next;

    // RAM ports
    logic                          ram_we;
    logic [hfa_pkg::IDX_W-1:0]     ram_waddr;
    logic [hfa_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [hfa_pkg::IDX_W-1:0]     ram_raddr;
    logic [hfa_pkg::ENTRY_W-1:0]   ram_rdata;

    hfa_pkg::hole_entry_t          rd_entry;
    hfa_pkg::hole_entry_t          wr_entry;
    logic                          fits;
    logic                          take;
    logic                          scan_issue;
    logic                          shift_issue;
    logic                          shift_last;
    logic                          full;
    logic [hfa_pkg::CNT_W-1:0]     ptr_plus1;
    logic [hfa_pkg::CNT_W-1:0]     count_m1;

    hfa_ram #(
        .WIDTH (hfa_pkg::ENTRY_W),
        .DEPTH (hfa_pkg::MAX_HOLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry    = hfa_pkg::hole_entry_t'(ram_rdata);
    assign full        = (count_reg >= hfa_pkg::CNT_W'(hfa_pkg::MAX_HOLES));
    assign ptr_plus1   = hfa_pkg::CNT_W'(ptr_reg) + hfa_pkg::CNT_W'(1);
    assign count_m1    = count_reg - hfa_pkg::CNT_W'(1);
    assign shift_last  = (ptr_plus1 >= count_reg);
    assign scan_issue  = cmd.scan && (scan_idx_reg < count_reg);
    assign shift_issue = cmd.shift && !shift_last;

    // Fit test on the entry returned by the RAM
    always_comb
    begin
        fits = rd_entry.free && (rd_entry.size >= item_reg.request_size);
        case (fit_mode_reg)
            hfa_pkg::FIT_BEST:
            begin
                take = fits && (rd_entry.size <= memory_size_reg)
                       && (!found_reg || (rd_entry.size < pick_size_reg));
            end
            hfa_pkg::FIT_WORST:
            begin
                take = fits && (!found_reg || (rd_entry.size > pick_size_reg));
            end
            default:
            begin
                take = fits && !found_reg;
            end
        endcase
    end

    // Read address: shift reads one ahead, scan walks from the start
    always_comb
    begin
        if (cmd.shift)
        begin
            ram_raddr = ptr_plus1[hfa_pkg::IDX_W-1:0];
        end
        else
        begin
            ram_raddr = scan_idx_reg[hfa_pkg::IDX_W-1:0];
        end
    end

    // Write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[hfa_pkg::IDX_W-1:0];
        wr_entry  = rd_entry;
        if (pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
        end
        else if (cmd.wr_used)
        begin
            ram_we        = 1'b1;
            ram_waddr     = count_m1[hfa_pkg::IDX_W-1:0];
            wr_entry.free = 1'b0;
            wr_entry.size = item_reg.request_size;
            wr_entry.base = pick_base_reg;
        end
        else if (cmd.wr_rem)
        begin
            ram_we        = 1'b1;
            wr_entry.free = 1'b1;
            wr_entry.size = pick_size_reg - item_reg.request_size;
            wr_entry.base = pick_base_reg
                            + item_reg.request_size[hfa_pkg::ADDR_BITS-1:0];
        end
        else if (cmd.table_op && (item_reg.func == hfa_pkg::FUNC_APPEND) && !full)
        begin
            ram_we        = 1'b1;
            wr_entry.free = item_reg.entry_free;
            wr_entry.size = item_reg.entry_size;
            wr_entry.base = item_reg.entry_base;
        end
    end

    assign ram_wdata = hfa_pkg::ENTRY_W'(wr_entry);

    // Next-state logic
    always_comb
    begin
        fit_mode_next    = fit_mode_reg;
        memory_size_next = memory_size_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        eval_vld_next    = scan_issue;
        eval_idx_next    = scan_idx_reg[hfa_pkg::IDX_W-1:0];
        found_next       = found_reg;
        pend_next        = shift_issue;
        pend_addr_next   = ptr_reg;
        item_next        = item_reg;
        pick_idx_next    = pick_idx_reg;
        pick_base_next   = pick_base_reg;
        pick_size_next   = pick_size_reg;
        sum_next         = sum_reg;
        ptr_next         = ptr_reg;
        res_status_next  = res_status_reg;
        res_base_next    = res_base_reg;
        out_data_next    = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                hfa_pkg::CFG_FIT_MODE:    fit_mode_next    = cfg_data[hfa_pkg::FIT_W-1:0];
                hfa_pkg::CFG_MEMORY_SIZE: memory_size_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.take_item)
        begin
            item_next     = in_data;
            scan_idx_next = '0;
            found_next    = 1'b0;
            sum_next      = '0;
        end

        if (scan_issue)
        begin
            scan_idx_next = scan_idx_reg + hfa_pkg::CNT_W'(1);
        end

        // Evaluate the entry read in the previous cycle
        if (eval_vld_reg)
        begin
            if (take)
            begin
                found_next     = 1'b1;
                pick_idx_next  = eval_idx_reg;
                pick_base_next = rd_entry.base;
                pick_size_next = rd_entry.size;
            end
            if (rd_entry.free)
            begin
                sum_next = sum_reg + hfa_pkg::SUM_W'(rd_entry.size);
            end
        end

        if (cmd.decide)
        begin
            ptr_next      = pick_idx_reg;
            res_base_next = '0;
            if (!found_reg)
            begin
                res_status_next = (sum_reg >= hfa_pkg::SUM_W'(item_reg.request_size))
                                  ? hfa_pkg::STS_COMPACT : hfa_pkg::STS_NO_SPACE;
            end
            else
            begin
                res_status_next = hfa_pkg::STS_FULL;
            end
        end

        if (shift_issue)
        begin
            ptr_next = ptr_plus1[hfa_pkg::IDX_W-1:0];
        end

        if (cmd.wr_rem)
        begin
            count_next      = count_reg + hfa_pkg::CNT_W'(1);
            res_status_next = hfa_pkg::STS_ALLOCATED;
            res_base_next   = pick_base_reg;
        end

        if (cmd.table_op)
        begin
            res_base_next   = '0;
            res_status_next = hfa_pkg::STS_OP_DONE;
            case (item_reg.func)
                hfa_pkg::FUNC_APPEND:
                begin
                    if (full)
                    begin
                        res_status_next = hfa_pkg::STS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + hfa_pkg::CNT_W'(1);
                    end
                end
                hfa_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                default: ;
            endcase
        end

        if (cmd.load_out)
        begin
            out_data_next.status       = res_status_reg;
            out_data_next.granted_base = res_base_reg;
            out_data_next.hole_count   = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= hfa_pkg::FIT_MODE_RESET;
            memory_size_reg <= hfa_pkg::MEMORY_SIZE_RESET;
            count_reg       <= '0;
            scan_idx_reg    <= '0;
            eval_vld_reg    <= 1'b0;
            found_reg       <= 1'b0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            fit_mode_reg    <= fit_mode_next;
            memory_size_reg <= memory_size_next;
            count_reg       <= count_next;
            scan_idx_reg    <= scan_idx_next;
            eval_vld_reg    <= eval_vld_next;
            found_reg       <= found_next;
            pend_reg        <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        eval_idx_reg   <= eval_idx_next;
        pick_idx_reg   <= pick_idx_next;
        pick_base_reg  <= pick_base_next;
        pick_size_reg  <= pick_size_next;
        sum_reg        <= sum_next;
        ptr_reg        <= ptr_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        out_data_reg   <= out_data_next;
    end

    assign sts.new_func   = in_data.func;
    assign sts.scan_done  = (scan_idx_reg >= count_reg) && !eval_vld_reg;
    assign sts.found      = found_reg;
    assign sts.full       = full;
    assign sts.shift_last = shift_last;
    assign out_data       = out_data_reg;

    // Table never grows past its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hfa_pkg::CNT_W'(hfa_pkg::MAX_HOLES))
        else $error("hole count above table depth");

    // Shift writes stay inside the live table
    a_shift_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (hfa_pkg::CNT_W'(pend_addr_reg) < count_reg))
        else $error("shift write outside live entries");

    // The remainder entry never lands beyond the last slot
    a_rem_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_rem |-> !full)
        else $error("remainder written into a full table");

    // A chosen hole is always a live entry
    a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (hfa_pkg::CNT_W'(pick_idx_reg) < count_reg))
        else $error("picked hole outside live entries");

endmodule

// ----- sv/hfa_ctrl.sv -----
// Controller of the hole-fit allocator: sequences scan, split, table operations and result transfer.
`timescale 1ns / 1ps

module hfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  hfa_pkg::hfa_sts_t  sts,
    output hfa_pkg::hfa_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_DECIDE   = 8'b0000_0100,
        S_SHIFT    = 8'b0000_1000,
        S_WR_USED  = 8'b0001_0000,
        S_WR_REM   = 8'b0010_0000,
        S_TABLE_OP = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = (sts.new_func == hfa_pkg::FUNC_ALLOC) ? S_SCAN
                                                                          : S_TABLE_OP;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = (sts.found && !sts.full) ? S_SHIFT : S_RESULT;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_last)
                begin
                    state_next = S_WR_USED;
                end
            end
            S_WR_USED:
            begin
                cmd.wr_used = 1'b1;
                state_next  = S_WR_REM;
            end
            S_WR_REM:
            begin
                cmd.wr_rem = 1'b1;
                state_next = S_RESULT;
            end
            S_TABLE_OP:
            begin
                cmd.table_op = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // A finished result waits while the output register is still held
    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_valid_reg && out_stall) |=> (state_reg == S_RESULT))
        else $error("result overwrote an untaken transfer");

    // Shift keeps going until the last entry has moved
    a_shift_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && !sts.shift_last) |=> (state_reg == S_SHIFT))
        else $error("shift left early");

endmodule

// ----- sv/hole_fit_allocator.sv -----
// Top level of the hole-fit allocator: controller, datapath and port wiring.
`timescale 1ns / 1ps

// Hole-fit allocator.
// Input channel (in_valid / in_stall / in_data): one transfer per item. func selects
// allocate, append entry or clear table. Output channel (out_valid / out_stall /
// out_data): exactly one result transfer per item, in item order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is fit_mode,
// index 1 is memory_size. cfg_ready is always high; write only while the block is idle.
// Sequence: append / clear / unused func go from idle through a table operation to
//   the result. Allocate scans the live entries and decides; on a split of entry k it
//   moves the entries behind k down one slot each, writes the used entry and the
//   remainder, then loads the result. A split needs a free slot, so 31 live entries
//   is the largest table that can still split.
// The scan walks the hole table one entry per cycle through the table RAM's single
// read port; the split then moves the tail down one entry per cycle, read and write
// overlapped. One item is in work at a time; in_stall is low only when idle, so the
// next transfer is taken only once the block has gone back to idle after a result.
// The result sits in an output register, so a new item is taken while it waits.
// A stalled receiver holds the result; a following result waits inside the block.
// Reset: table empty, fit_mode first fit, memory_size 4096, no result pending.
// Table RAM contents need no clearing: only live entries are ever read.

module hole_fit_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  hfa_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output hfa_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hfa_pkg::hfa_cmd_t cmd;
    hfa_pkg::hfa_sts_t sts;
    logic              cfg_we;

    // Register writes complete in the cycle they are offered
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    hfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    hfa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule
